// ===== hdl/uis_pkg.sv =====
// Shared types, codes and sizes of the unique id item stack.
package uis_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 8;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic REG_ORDERING_MODE = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ID_W-1:0]   item_id;
        logic [DATA_W-1:0] item_data;
    } t_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        position;
        logic              top_valid;
        logic [ID_W-1:0]   top_id;
        logic [DATA_W-1:0] top_data;
        logic [4:0]        entry_count;
    } t_result;

endpackage

// ===== hdl/uis_mem.sv =====
// Entry memory: one write port and one registered read port.
module uis_mem #(
    parameter int DEPTH = uis_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  uis_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_rd_addr,
    output uis_pkg::t_entry o_rd_data
);

    uis_pkg::t_entry r_mem [DEPTH];
    uis_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/uis_ctrl.sv =====
// Sequencer: search walk, shift walk, placement and top read over the entry memory.
module uis_ctrl #(
    parameter int DEPTH = uis_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  uis_pkg::t_item   i_item,
    input  logic             i_mode,
    output logic             o_busy,
    output logic             o_done,
    output uis_pkg::t_result o_result,
    output logic             o_wr_en,
    output logic [IW-1:0]    o_wr_addr,
    output uis_pkg::t_entry  o_wr_data,
    output logic             o_rd_en,
    output logic [IW-1:0]    o_rd_addr,
    input  uis_pkg::t_entry  i_rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_TOPRD  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_op, n_op;
    logic [uis_pkg::ID_W-1:0]    r_id, n_id;
    logic [uis_pkg::DATA_W-1:0]  r_data, n_data;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_rd_idx, n_rd_idx;
    logic                        r_issue, n_issue;
    logic                        r_vld, n_vld;
    logic [CW-1:0]               r_dst, n_dst;
    logic                        r_hit, n_hit;
    logic [CW-1:0]               r_hit_idx, n_hit_idx;
    logic                        r_lt, n_lt;
    logic [CW-1:0]               r_lt_idx, n_lt_idx;
    logic [CW-1:0]               r_pos, n_pos;
    logic                        r_up, n_up;
    logic [2:0]                  r_status, n_status;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] hit_p1;
    logic [CW-1:0] add_pos;
    logic [CW+3:0] pos_ext;
    logic [CW+4:0] cnt_ext;
    logic          top_vld;

    assign cnt_m1  = r_count - 1'b1;
    assign hit_p1  = r_hit_idx + 1'b1;
    assign add_pos = (i_mode && r_lt) ? r_lt_idx : r_count;
    assign pos_ext = {4'b0, r_pos};
    assign cnt_ext = {5'b0, r_count};
    assign top_vld = (r_count != '0);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_id      = r_id;
        n_data    = r_data;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_issue   = r_issue;
        n_vld     = r_vld;
        n_dst     = r_dst;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_lt      = r_lt;
        n_lt_idx  = r_lt_idx;
        n_pos     = r_pos;
        n_up      = r_up;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_rd_idx[IW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_dst[IW-1:0];
        o_wr_data = i_rd_data;
        o_done    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_item.operation;
                    n_id     = i_item.item_id;
                    n_data   = i_item.item_data;
                    n_hit    = 1'b0;
                    n_lt     = 1'b0;
                    n_vld    = 1'b0;
                    n_issue  = 1'b0;
                    n_rd_idx = '0;
                    n_pos    = '0;
                    if (i_item.operation == uis_pkg::OP_ADD && r_count == FULL_COUNT) begin
                        n_status = uis_pkg::ST_FULL;
                        n_state  = S_TOPRD;
                    end else if (i_item.operation == uis_pkg::OP_ADD ||
                                 i_item.operation == uis_pkg::OP_REMOVE) begin
                        n_state = S_SEARCH;
                    end else if (r_count == '0) begin
                        n_status = uis_pkg::ST_EMPTY;
                        n_state  = S_TOPRD;
                    end else begin
                        n_status = uis_pkg::ST_OK;
                        n_pos    = cnt_m1;
                        n_state  = S_TOPRD;
                    end
                end
            end
            S_SEARCH: begin
                if (r_rd_idx < r_count) begin
                    o_rd_en  = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_vld    = 1'b1;
                    n_dst    = r_rd_idx;
                end else begin
                    n_vld = 1'b0;
                end
                if (r_vld) begin
                    if (i_rd_data.id == r_id && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_dst;
                    end
                    if (i_rd_data.id <= r_id && !r_lt) begin
                        n_lt     = 1'b1;
                        n_lt_idx = r_dst;
                    end
                end
                if (!(r_rd_idx < r_count) && !r_vld) begin
                    if (r_op == uis_pkg::OP_ADD) begin
                        if (r_hit) begin
                            n_status = uis_pkg::ST_DUP;
                            n_state  = S_TOPRD;
                        end else begin
                            n_pos = add_pos;
                            if (add_pos == r_count) begin
                                n_state = S_PLACE;
                            end else begin
                                n_up     = 1'b1;
                                n_rd_idx = cnt_m1;
                                n_issue  = 1'b1;
                                n_state  = S_SHIFT;
                            end
                        end
                    end else if (!r_hit) begin
                        n_status = uis_pkg::ST_NOTFOUND;
                        n_state  = S_TOPRD;
                    end else begin
                        n_pos = r_hit_idx;
                        if (hit_p1 < r_count) begin
                            n_up     = 1'b0;
                            n_rd_idx = hit_p1;
                            n_issue  = 1'b1;
                            n_state  = S_SHIFT;
                        end else begin
                            n_count  = cnt_m1;
                            n_status = uis_pkg::ST_OK;
                            n_state  = S_TOPRD;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_issue) begin
                    o_rd_en = 1'b1;
                    n_vld   = 1'b1;
                    if (r_up) begin
                        n_dst = r_rd_idx + 1'b1;
                        if (r_rd_idx == r_pos) begin
                            n_issue = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx - 1'b1;
                        end
                    end else begin
                        n_dst = r_rd_idx - 1'b1;
                        if (r_rd_idx == cnt_m1) begin
                            n_issue = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx + 1'b1;
                        end
                    end
                end else begin
                    n_vld = 1'b0;
                end
                if (r_vld) begin
                    o_wr_en = 1'b1;
                end
                if (!r_issue && !r_vld) begin
                    if (r_up) begin
                        n_state = S_PLACE;
                    end else begin
                        n_count  = cnt_m1;
                        n_status = uis_pkg::ST_OK;
                        n_state  = S_TOPRD;
                    end
                end
            end
            S_PLACE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos[IW-1:0];
                o_wr_data = '{id: r_id, data: r_data};
                n_count   = r_count + 1'b1;
                n_status  = uis_pkg::ST_OK;
                n_state   = S_TOPRD;
            end
            S_TOPRD: begin
                o_rd_en   = top_vld;
                o_rd_addr = cnt_m1[IW-1:0];
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_data    <= n_data;
        r_rd_idx  <= n_rd_idx;
        r_dst     <= n_dst;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_lt      <= n_lt;
        r_lt_idx  <= n_lt_idx;
        r_pos     <= n_pos;
        r_up      <= n_up;
        r_status  <= n_status;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_result.status      = r_status;
    assign o_result.position    = pos_ext[3:0];
    assign o_result.top_valid   = top_vld;
    assign o_result.top_id      = top_vld ? i_rd_data.id : '0;
    assign o_result.top_data    = top_vld ? i_rd_data.data : '0;
    assign o_result.entry_count = cnt_ext[4:0];

endmodule

// ===== hdl/unique_id_item_stack.sv =====
// Top level: configuration register port, sequencer and entry memory.
// Read top: after start, a top read and then the result beat. Add and remove: a search walk
// over the stored entries, a shift walk over the entries moved (if any), placement (add only),
// a top read and the result beat, the walks using the memory's single read port; an add to a full
// store skips to the top read. The next start is taken in the cycle after the result beat.
// Results are shown for one cycle and cannot be stalled; busy holds off the next start.
// Synchronous reset empties the store and clears the ordering mode; no clearing pass.
module unique_id_item_stack #(
    parameter int DEPTH = uis_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  uis_pkg::t_item              i_item,
    output logic                        o_done,
    output uis_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uis_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic            r_mode;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    uis_pkg::t_entry wr_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    uis_pkg::t_entry rd_data;
    logic            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == uis_pkg::REG_ORDERING_MODE);
    assign prdata  = reg_sel ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_mode <= pwdata[0];
        end
    end

    uis_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_mode    (r_mode),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    uis_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the unique id item stack, with its own store predictor.
module tb_top;
    import uis_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 20;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int PHASES         = 6;

    localparam logic [1:0] OP_READ_ALT = 2'd3;
    localparam bit         MODE_LIFO   = 1'b0;
    localparam bit         MODE_SORTED = 1'b1;
    localparam logic [PADDR_W-1:0] ADDR_ORDERING_MODE = PADDR_W'(4 * int'(REG_ORDERING_MODE));

    class stack_scoreboard;
        logic [ID_W-1:0]   ids [DEPTH];
        logic [DATA_W-1:0] datas [DEPTH];
        int                fill;
        bit                sorted;
        t_result           pending_results [$];
        int                errors;

        function new();
            fill   = 0;
            sorted = MODE_LIFO;
            errors = 0;
            foreach (ids[k]) begin
                ids[k]   = '0;
                datas[k] = '0;
            end
        endfunction

        function int find_slot(logic [ID_W-1:0] id);
            for (int k = 0; k < fill; k++) begin
                if (ids[k] == id) return k;
            end
            return -1;
        endfunction

        function void note_item(t_item it);
            t_result    r;
            int         slot;
            logic [2:0] st;
            slot = 0;
            st   = ST_OK;
            case (it.operation)
                OP_ADD: begin
                    if (fill >= DEPTH) begin
                        st = ST_FULL;
                    end else if (find_slot(it.item_id) >= 0) begin
                        st = ST_DUP;
                    end else begin
                        slot = fill;
                        if (sorted) begin
                            slot = 0;
                            while (slot < fill && ids[slot] > it.item_id) slot++;
                            for (int k = fill; k > slot; k--) begin
                                ids[k]   = ids[k-1];
                                datas[k] = datas[k-1];
                            end
                        end
                        ids[slot]   = it.item_id;
                        datas[slot] = it.item_data;
                        fill++;
                    end
                end
                OP_REMOVE: begin
                    slot = find_slot(it.item_id);
                    if (slot < 0) begin
                        st   = ST_NOTFOUND;
                        slot = 0;
                    end else begin
                        for (int k = slot; k + 1 < fill; k++) begin
                            ids[k]   = ids[k+1];
                            datas[k] = datas[k+1];
                        end
                        fill--;
                        ids[fill]   = '0;
                        datas[fill] = '0;
                    end
                end
                default: begin
                    if (fill == 0) st = ST_EMPTY;
                    else slot = fill - 1;
                end
            endcase
            r.status      = st;
            r.position    = slot[3:0];
            r.entry_count = fill[4:0];
            if (fill > 0) begin
                r.top_valid = 1'b1;
                r.top_id    = ids[fill-1];
                r.top_data  = datas[fill-1];
            end else begin
                r.top_valid = 1'b0;
                r.top_id    = '0;
                r.top_data  = '0;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("position", want.position, got.position);
            compare_field("top_valid", want.top_valid, got.top_valid);
            compare_field("top_id", want.top_id, got.top_id);
            compare_field("top_data", want.top_data, got.top_data);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_done;
    t_result              o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    stack_scoreboard sb;
    bit              idle_enabled;
    int              idle_cycles;

    unique_id_item_stack #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_item it);
        if (idle_enabled && $urandom_range(99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 45)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] data);
        t_item it;
        it.operation = op;
        it.item_id   = id;
        it.item_data = data;
        send_item(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ordering_mode(input bit mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ORDERING_MODE;
        pwdata  <= 32'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.sorted = mode;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(mode)) begin
            $display("%0t: ordering_mode read mismatch: expected %0h, actual %0h",
                     $time, 32'(mode), prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_item random_item(int add_pct);
        t_item it;
        int    r;
        it.item_id   = 8'($urandom_range(255));
        it.item_data = $urandom();
        it.operation = OP_READ;
        r = $urandom_range(99);
        if (r < 8) begin
            it.operation = 2'($urandom_range(3));
        end else if (r < 8 + add_pct) begin
            it.operation = OP_ADD;
            if (sb.fill > 0 && $urandom_range(9) == 0)
                it.item_id = sb.ids[$urandom_range(sb.fill - 1)];
        end else if (r < 92) begin
            it.operation = OP_REMOVE;
            if (sb.fill > 0 && $urandom_range(9) != 0)
                it.item_id = sb.ids[$urandom_range(sb.fill - 1)];
        end else begin
            it.operation = $urandom_range(1) ? OP_READ : OP_READ_ALT;
        end
        return it;
    endfunction

    initial begin
        int add_pct;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_cycles  = 0;
        idle_enabled = 1'b1;
        sb           = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fields(OP_READ, 8'h00, 32'h0000_0000);
        send_fields(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF);
        send_fields(OP_ADD, 8'h00, 32'h0000_0000);
        send_fields(OP_ADD, 8'hFF, 32'hFFFF_FFFF);
        send_fields(OP_ADD, 8'hFF, 32'h1234_5678);
        send_fields(OP_READ_ALT, 8'h5A, 32'hDEAD_BEEF);
        send_fields(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_fields(OP_REMOVE, 8'hFF, 32'h0000_0000);
        for (int k = 0; k < DEPTH; k++)
            send_fields(OP_ADD, 8'(8'h80 ^ (k * 17)), {4{8'(k)}} ^ 32'hA5A5_5A5A);
        send_fields(OP_ADD, 8'h80, 32'h0000_0001);
        send_fields(OP_ADD, 8'h01, 32'h8000_0000);
        send_fields(OP_READ, 8'h00, 32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            write_ordering_mode((phase % 2 == 0) ? MODE_SORTED : MODE_LIFO);
            idle_enabled = (phase != 2);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                add_pct = ((n / 40) % 2 == 0) ? 25 : 62;
                send_item(random_item(add_pct));
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/uis_pkg.sv
hdl/uis_mem.sv
hdl/uis_ctrl.sv
hdl/unique_id_item_stack.sv
sim/tb_top.sv
